// ----- rtl/pce_pkg.sv -----
// Package for the piecewise cubic evaluator: widths, knot-store sizing, function codes.
// Holds the shared request struct, 48-bit saturation limits and the knot-count clamp.
// No dependencies.
package pce_pkg;

  localparam int MAX_KNOTS = 256;
  localparam int AW        = $clog2(MAX_KNOTS);
  localparam int DW        = 48;
  localparam int CW        = 9;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic signed [DW-1:0] W48_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] W48_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic                 func;
    logic [7:0]           entry_index;
    logic signed [DW-1:0] knot_position;
    logic signed [DW-1:0] coef_constant;
    logic signed [DW-1:0] coef_linear;
    logic signed [DW-1:0] coef_square;
    logic signed [DW-1:0] coef_cube;
    logic signed [DW-1:0] query_point;
  } req_t;

  function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] n);
    logic [CW-1:0] top;
    logic [CW-1:0] r;
    top = (MAX_KNOTS < 256) ? CW'(MAX_KNOTS) : CW'(256);
    r = n;
    if (r < CW'(2)) r = CW'(2);
    if (r > top) r = top;
    return r;
  endfunction

endpackage

// ----- rtl/pce_front.sv -----
// Front end of the piecewise cubic evaluator: input transaction capture into a two-entry queue.
// Depends on pce_pkg.
module pce_front import pce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_ready,
  output req_t q_req
);

  req_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
  end

endmodule

// ----- rtl/pce_back.sv -----
// Back end of the piecewise cubic evaluator: knot memories, binary search, Horner evaluation.
// Depends on pce_pkg.
module pce_back import pce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CW-1:0]        knots_in_use,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  req_t                 q_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_spline_value,
  output logic [7:0]           out_segment_found,
  output logic                 out_out_of_range
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD0   = 11'b00000000010,
    S_RDL   = 11'b00000000100,
    S_CHK   = 11'b00000001000,
    S_SRCH  = 11'b00000010000,
    S_SWT   = 11'b00000100000,
    S_FETCH = 11'b00001000000,
    S_FWT   = 11'b00010000000,
    S_MUL   = 11'b00100000000,
    S_ADD   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  logic signed [DW-1:0] knot_mem  [MAX_KNOTS];
  logic signed [DW-1:0] a_mem     [MAX_KNOTS];
  logic signed [DW-1:0] b_mem     [MAX_KNOTS];
  logic signed [DW-1:0] c_mem     [MAX_KNOTS];
  logic signed [DW-1:0] d_mem     [MAX_KNOTS];

  state_t               st_r, st_nxt;
  logic [AW-1:0]        raddr;
  logic signed [DW-1:0] kq_r, aq_r, bq_r, cq_r, dq_r;
  logic signed [DW-1:0] k0_r, k0_nxt;
  logic signed [DW-1:0] t_r, t_nxt;
  logic [CW-1:0]        n_r, n_nxt, lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [AW-1:0]        seg_r, seg_nxt;
  logic signed [DW:0]   u_r, u_nxt;
  logic signed [DW-1:0] acc_r, acc_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [1:0]           pp_r, pp_nxt;
  logic [96:0]          mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [DW-1:0] ov_r, ov_nxt;
  logic [7:0]           os_r, os_nxt;
  logic                 oor_r, oor_nxt;
  logic                 wr_en;

  logic [DW-1:0]        absr;
  logic [DW:0]          absu;
  logic [23:0]          mr;
  logic [24:0]          mu;
  logic [48:0]          pp;
  logic [96:0]          term;
  logic [97:0]          rnd;
  logic [DW-1:0]        pm;
  logic signed [DW+1:0] sum;
  logic signed [DW-1:0] coef;

  assign mid   = (lo_r + hi_r) >> 1;
  assign wr_en = (st_r == S_IDLE) && q_valid && (q_req.func == FUNC_WRITE)
                 && ({1'b0, q_req.entry_index} < CW'(MAX_KNOTS));
  assign q_ready = (st_r == S_IDLE) &&
                   ((q_req.func == FUNC_WRITE) || !out_valid);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      knot_mem[q_req.entry_index[AW-1:0]] <= q_req.knot_position;
      a_mem[q_req.entry_index[AW-1:0]]    <= q_req.coef_constant;
      b_mem[q_req.entry_index[AW-1:0]]    <= q_req.coef_linear;
      c_mem[q_req.entry_index[AW-1:0]]    <= q_req.coef_square;
      d_mem[q_req.entry_index[AW-1:0]]    <= q_req.coef_cube;
    end
    kq_r <= knot_mem[raddr];
    aq_r <= a_mem[raddr];
    bq_r <= b_mem[raddr];
    cq_r <= c_mem[raddr];
    dq_r <= d_mem[raddr];
  end

  always_comb begin
    absr = acc_r[DW-1] ? DW'(-acc_r) : acc_r;
    absu = u_r[DW] ? (DW+1)'(-u_r) : u_r;
    mr   = pp_r[0] ? absr[DW-1:24] : absr[23:0];
    mu   = pp_r[1] ? absu[DW:24] : {1'b0, absu[23:0]};
    pp   = 49'(mr) * 49'(mu);
    case (pp_r)
      2'd0:    term = 97'(pp);
      2'd3:    term = 97'(pp) << 48;
      default: term = 97'(pp) << 24;
    endcase
    rnd  = {1'b0, mag_r} + (neg_r ? 98'd32767 : 98'd32768);
    if (rnd[97:64] != '0) pm = neg_r ? W48_MIN : W48_MAX;
    else if (!neg_r && rnd[63:16] > 48'(W48_MAX)) pm = W48_MAX;
    else if (neg_r && rnd[63:16] > 48'(W48_MIN)) pm = W48_MIN;
    else pm = neg_r ? -rnd[63:16] : rnd[63:16];
    case (step_r)
      2'd0:    coef = cq_r;
      2'd1:    coef = bq_r;
      default: coef = aq_r;
    endcase
    sum = {{2{pm[DW-1]}}, pm} + {{2{coef[DW-1]}}, coef};
  end

  always_comb begin
    st_nxt   = st_r;
    raddr    = '0;
    k0_nxt   = k0_r;
    t_nxt    = t_r;
    n_nxt    = n_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    seg_nxt  = seg_r;
    u_nxt    = u_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    pp_nxt   = pp_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    ov_nxt   = ov_r;
    os_nxt   = os_r;
    oor_nxt  = oor_r;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid && q_ready && q_req.func == FUNC_QUERY) begin
          n_nxt  = clamp_count(knots_in_use);
          t_nxt  = q_req.query_point;
          st_nxt = S_RD0;
        end
      end
      S_RD0: begin
        raddr  = '0;
        st_nxt = S_RDL;
      end
      S_RDL: begin
        raddr  = AW'(n_r - CW'(1));
        k0_nxt = kq_r;
        st_nxt = S_CHK;
      end
      S_CHK: begin
        raddr = AW'(n_r - CW'(1));
        if (t_r < k0_r || t_r > kq_r) begin
          ov_nxt = '0; os_nxt = '0; oor_nxt = 1'b1; st_nxt = S_OUT;
        end else if (t_r == kq_r) begin
          ov_nxt = aq_r; os_nxt = 8'(n_r - CW'(1)); oor_nxt = 1'b0; st_nxt = S_OUT;
        end else begin
          lo_nxt = '0; hi_nxt = n_r; st_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        raddr = AW'(mid);
        if (lo_r < hi_r) st_nxt = S_SWT;
        else begin
          seg_nxt = (lo_r == '0) ? '0 : AW'(lo_r - CW'(1));
          st_nxt  = S_FETCH;
        end
      end
      S_SWT: begin
        raddr = AW'(mid);
        if (kq_r <= t_r) lo_nxt = mid + CW'(1);
        else hi_nxt = mid;
        st_nxt = S_SRCH;
      end
      S_FETCH: begin
        raddr  = seg_r;
        st_nxt = S_FWT;
      end
      S_FWT: begin
        raddr    = seg_r;
        u_nxt    = {t_r[DW-1], t_r} - {kq_r[DW-1], kq_r};
        acc_nxt  = dq_r;
        step_nxt = 2'd0;
        pp_nxt   = 2'd0;
        st_nxt   = S_MUL;
      end
      S_MUL: begin
        raddr   = seg_r;
        neg_nxt = acc_r[DW-1] != u_r[DW];
        mag_nxt = ((pp_r == 2'd0) ? '0 : mag_r) + term;
        pp_nxt  = pp_r + 2'd1;
        if (pp_r == 2'd3) st_nxt = S_ADD;
      end
      S_ADD: begin
        raddr = seg_r;
        if (sum > (DW+2)'(W48_MAX)) acc_nxt = W48_MAX;
        else if (sum < (DW+2)'(W48_MIN)) acc_nxt = W48_MIN;
        else acc_nxt = DW'(sum);
        if (step_r == 2'd2) begin
          ov_nxt = acc_nxt; os_nxt = 8'(seg_r); oor_nxt = 1'b0; st_nxt = S_OUT;
        end else begin
          step_nxt = step_r + 2'd1;
          st_nxt   = S_MUL;
        end
      end
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic ov_valid_r, ov_valid_nxt;
  always_comb begin
    ov_valid_nxt = out_valid;
    if (out_valid && out_ready) ov_valid_nxt = 1'b0;
    if (st_r == S_OUT) ov_valid_nxt = 1'b1;
  end
  assign out_valid = ov_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      ov_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      ov_valid_r <= ov_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k0_r   <= k0_nxt;
    t_r    <= t_nxt;
    n_r    <= n_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    seg_r  <= seg_nxt;
    u_r    <= u_nxt;
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
    pp_r   <= pp_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    ov_r   <= ov_nxt;
    os_r   <= os_nxt;
    oor_r  <= oor_nxt;
    if (st_r == S_OUT) begin
      out_spline_value  <= ov_r;
      out_segment_found <= os_r;
      out_out_of_range  <= oor_r;
    end
  end

endmodule

// ----- rtl/piecewise_cubic_evaluator_unit.sv -----
// Top level of the piecewise cubic evaluator: config register, front queue, back end.
// Depends on pce_pkg, pce_front and pce_back.
//
// Input channel (in_valid/in_ready): in_func 0 writes a knot entry at in_entry_index;
// in_func 1 evaluates in_query_point against the first knots_in_use knots (2..256).
// Output channel (out_valid/out_ready): one transaction per query, none per write.
// Config channel (cfg_valid/cfg_ready): writes knots_in_use, always ready.
// A two-entry queue decouples input capture from the evaluator.
// An in-range query passes through the queue, reads the first and last knot to
// bound-check the query point, runs the bisection steps (two to nine, each a read and
// a wait for the registered single read port of the knot memory), fetches the
// segment, then runs the Horner steps (four 24x25 partial products, then round,
// add and saturate). Out-of-range and last-knot queries skip the search and the
// Horner steps. Queries are handled one at a time.
// Reset clears control state and sets knots_in_use to 2; the knot memories
// hold whatever was written. When out_ready is low the result holds in the
// output register and the next query waits; writes still proceed.
module piecewise_cubic_evaluator_unit import pce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CW-1:0]        cfg_knots_in_use,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [7:0]           in_entry_index,
  input  logic signed [DW-1:0] in_knot_position,
  input  logic signed [DW-1:0] in_coef_constant,
  input  logic signed [DW-1:0] in_coef_linear,
  input  logic signed [DW-1:0] in_coef_square,
  input  logic signed [DW-1:0] in_coef_cube,
  input  logic signed [DW-1:0] in_query_point,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_spline_value,
  output logic [7:0]           out_segment_found,
  output logic                 out_out_of_range
);

  logic [CW-1:0] knots_r;
  req_t          in_req, q_req;
  logic          q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) knots_r <= CW'(2);
    else if (cfg_valid) knots_r <= cfg_knots_in_use;
  end

  always_comb begin
    in_req.func          = in_func;
    in_req.entry_index   = in_entry_index;
    in_req.knot_position = in_knot_position;
    in_req.coef_constant = in_coef_constant;
    in_req.coef_linear   = in_coef_linear;
    in_req.coef_square   = in_coef_square;
    in_req.coef_cube     = in_coef_cube;
    in_req.query_point   = in_query_point;
  end

  pce_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  pce_back u_back (
    .clk(clk), .rst_n(rst_n), .knots_in_use(knots_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_spline_value(out_spline_value),
    .out_segment_found(out_segment_found),
    .out_out_of_range(out_out_of_range)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for piecewise_cubic_evaluator_unit: loads knot tables,
// runs directed and random queries, predicts every result and compares it.
// Depends on pce_pkg and the RTL of the evaluator.
module tb_top;
  import pce_pkg::*;

  localparam int    LIMIT   = 3000000;
  localparam int    SETTLE  = 80;
  localparam longint MAX48  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48  = -64'sh0000_8000_0000_0000;

  typedef struct {
    logic signed [DW-1:0] value;
    logic [7:0]           segment;
    logic                 oor;
  } spline_result_t;

  class spline_scoreboard;
    longint         knot[MAX_KNOTS];
    longint         ca[MAX_KNOTS];
    longint         cb[MAX_KNOTS];
    longint         cc[MAX_KNOTS];
    longint         cd[MAX_KNOTS];
    int             count_reg;
    spline_result_t awaited[$];
    int             mismatches;
    int             queries;
    int             outside;
    int             writes;

    function new();
      count_reg = 2;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function int active_knots();
      int n;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > MAX_KNOTS) n = MAX_KNOTS;
      return n;
    endfunction

    function longint sat48(longint v);
      if (v > MAX48) return MAX48;
      if (v < MIN48) return MIN48;
      return v;
    endfunction

    function longint round_product(longint r, longint u);
      bit           neg;
      logic [127:0] a;
      logic [127:0] b;
      logic [127:0] mag;
      logic [127:0] lim;
      neg = (r < 0) != (u < 0);
      a = (r < 0) ? 128'(-r) : 128'(r);
      b = (u < 0) ? 128'(-u) : 128'(u);
      mag = (a * b + (neg ? 128'd32767 : 128'd32768)) >> 16;
      lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
      if (mag > lim) mag = lim;
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    task note_input(logic func, logic [7:0] idx, longint kp, longint a, longint b,
                    longint c, longint d, longint t);
      spline_result_t res;
      int             n;
      int             lo;
      int             hi;
      int             mid;
      int             seg;
      longint         u;
      longint         r;
      if (func == FUNC_WRITE) begin
        knot[idx] = kp; ca[idx] = a; cb[idx] = b; cc[idx] = c; cd[idx] = d;
        writes++;
        return;
      end
      queries++;
      n = active_knots();
      res.oor = 1'b0;
      if (t < knot[0] || t > knot[n-1]) begin
        res.value = '0; res.segment = '0; res.oor = 1'b1;
        outside++;
      end else if (t == knot[n-1]) begin
        res.value = ca[n-1][DW-1:0]; res.segment = 8'(n - 1);
      end else begin
        lo = 0; hi = n;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (knot[mid] <= t) lo = mid + 1;
          else hi = mid;
        end
        seg = (lo == 0) ? 0 : lo - 1;
        u = t - knot[seg];
        r = cd[seg];
        r = sat48(round_product(r, u) + cc[seg]);
        r = sat48(round_product(r, u) + cb[seg]);
        r = sat48(round_product(r, u) + ca[seg]);
        res.value = r[DW-1:0]; res.segment = 8'(seg);
      end
      awaited = {awaited, res};
    endtask

    task check_result(logic signed [DW-1:0] value, logic [7:0] segment, logic oor);
      spline_result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result value %0d segment %0d", value, segment));
        return;
      end
      e = awaited.pop_front();
      if (value !== e.value)
        report($sformatf("spline_value %0d, expected %0d", value, e.value));
      if (segment !== e.segment)
        report($sformatf("segment_found %0d, expected %0d", segment, e.segment));
      if (oor !== e.oor)
        report($sformatf("out_of_range %0b, expected %0b", oor, e.oor));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CW-1:0]        cfg_knots_in_use;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_func;
  logic [7:0]           in_entry_index;
  logic signed [DW-1:0] in_knot_position;
  logic signed [DW-1:0] in_coef_constant;
  logic signed [DW-1:0] in_coef_linear;
  logic signed [DW-1:0] in_coef_square;
  logic signed [DW-1:0] in_coef_cube;
  logic signed [DW-1:0] in_query_point;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [DW-1:0] out_spline_value;
  logic [7:0]           out_segment_found;
  logic                 out_out_of_range;

  spline_scoreboard sb;
  int               cycles;
  int               stall_pct;
  int               gap_pct;
  int               stall_left;
  int               phases;

  piecewise_cubic_evaluator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_knots_in_use(cfg_knots_in_use),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_entry_index(in_entry_index), .in_knot_position(in_knot_position),
    .in_coef_constant(in_coef_constant), .in_coef_linear(in_coef_linear),
    .in_coef_square(in_coef_square), .in_coef_cube(in_coef_cube),
    .in_query_point(in_query_point),
    .out_valid(out_valid), .out_ready(out_ready), .out_spline_value(out_spline_value),
    .out_segment_found(out_segment_found), .out_out_of_range(out_out_of_range)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_func, in_entry_index, in_knot_position, in_coef_constant,
                    in_coef_linear, in_coef_square, in_coef_cube, in_query_point);

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_spline_value, out_segment_found, out_out_of_range);

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic longint rnd48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return longint'({{16{v[47]}}, v[47:0]});
  endfunction

  function automatic longint rnd_coef();
    logic [63:0] v;
    int          w;
    if ($urandom_range(0, 7) == 0) return rnd48();
    w = $urandom_range(4, 40);
    v = {$urandom, $urandom} & ((64'd1 << w) - 1);
    return $urandom_range(0, 1) ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint clamp48(longint v);
    return (v > MAX48) ? MAX48 : ((v < MIN48) ? MIN48 : v);
  endfunction

  task automatic send(logic func, logic [7:0] idx, longint kp, longint a, longint b,
                      longint c, longint d, longint t);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func = func; in_entry_index = idx; in_knot_position = kp[DW-1:0];
    in_coef_constant = a[DW-1:0]; in_coef_linear = b[DW-1:0];
    in_coef_square = c[DW-1:0]; in_coef_cube = d[DW-1:0];
    in_query_point = t[DW-1:0];
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_entry(int idx, longint kp);
    send(FUNC_WRITE, 8'(idx), kp, rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(), rnd48());
  endtask

  task automatic query(longint t);
    send(FUNC_QUERY, 8'($urandom), rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), t);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_knot_count(int value);
    drain();
    cfg_knots_in_use = CW'(value);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.count_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // table modes: 0 sorted narrow, 1 sorted over the negative half, 2 unsorted
  task automatic load_table(int mode);
    int     n;
    longint pos;
    longint step;
    n = sb.active_knots();
    pos = (mode == 1) ? MIN48 : longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    step = (mode == 1) ? (MAX48 / (n - 1)) : longint'($urandom_range(1, 1 << 22));
    for (int i = 0; i < n; i++) begin
      write_entry(i, (mode == 2) ? rnd48() : pos);
      pos = pos + ((mode == 0) ? longint'($urandom_range(1, 1 << 22)) : step);
    end
  endtask

  task automatic random_items(int count);
    int     n;
    int     s;
    int     k;
    longint lo;
    longint hi;
    for (int i = 0; i < count; i++) begin
      n = sb.active_knots();
      s = $urandom_range(0, n - 2);
      lo = sb.knot[s];
      hi = sb.knot[s + 1];
      k = $urandom_range(0, 99);
      if (i == count / 2) drain();
      if (k < 10) begin
        s = $urandom_range(0, n - 1);
        if ($urandom_range(0, 3) == 0)
          write_entry(s, rnd48());
        else if (s > 0 && s < n - 1 && sb.knot[s+1] - sb.knot[s-1] > 2)
          write_entry(s, sb.knot[s-1] + 1 +
                         longint'({$urandom, $urandom} % (sb.knot[s+1] - sb.knot[s-1] - 1)));
        else
          write_entry(s, sb.knot[s]);
      end else if (k < 20)
        query($urandom_range(0, 1) ? clamp48(sb.knot[0] - $urandom_range(1, 1 << 20))
                                   : clamp48(sb.knot[n-1] + $urandom_range(1, 1 << 20)));
      else if (k < 30) query(sb.knot[n-1]);
      else if (k < 40) query(sb.knot[$urandom_range(0, n - 1)]);
      else if (k < 90 && hi > lo)
        query(lo + longint'({$urandom, $urandom} % (hi - lo)));
      else query(rnd48());
    end
  endtask

  initial begin
    int counts[8] = '{256, 0, 511, 37, 3, 256, 1, 300};
    sb = new();
    stall_pct = 20; gap_pct = 30; phases = 0;
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_knots_in_use = '0;
    in_valid = 1'b0; in_func = FUNC_WRITE; in_entry_index = '0; in_knot_position = '0;
    in_coef_constant = '0; in_coef_linear = '0; in_coef_square = '0;
    in_coef_cube = '0; in_query_point = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    send(FUNC_WRITE, 8'd0, MIN48, MAX48, MAX48, MAX48, MAX48, 0);
    send(FUNC_WRITE, 8'd1, MAX48, MIN48, MIN48, MIN48, MIN48, 0);
    query(MIN48);
    query(MAX48);
    query(0);
    query(-1);
    send(FUNC_WRITE, 8'd0, MIN48, MIN48, MIN48, MIN48, MIN48, 0);
    query(1);
    query(MAX48 - 1);
    send(FUNC_WRITE, 8'd0, 0, 64'sd1 << 32, -(64'sd1 << 32), 64'sd1 << 31, 64'sd1, 0);
    send(FUNC_WRITE, 8'd1, 100 << 16, 7, 0, 0, 0, 0);
    query(-1);
    query((100 << 16) + 1);
    query(100 << 16);
    query(0);
    query(3 << 15);
    set_knot_count(3);
    send(FUNC_WRITE, 8'd1, 1000, 1, 2, 3, 4, 0);
    send(FUNC_WRITE, 8'd2, 10, 5, 0, 0, 0, 0);
    query(5);
    query(10);
    query(11);
    phases = 1;

    foreach (counts[p]) begin
      set_knot_count(counts[p]);
      stall_pct = (p % 3 == 1) ? 0 : 25;
      gap_pct = (p % 3 == 1) ? 0 : 30;
      load_table((p == 5) ? 1 : ((p == 6 || p == 3) ? 2 : 0));
      random_items(120);
      phases++;
    end

    in_valid = 1'b0;
    drain();
    while (sb.awaited.size() != 0) report_leftover();
    $display("ran %0d phases: %0d knot writes, %0d queries, %0d of them out of range",
             phases, sb.writes, sb.queries, sb.outside);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  task automatic report_leftover();
    spline_result_t e;
    e = sb.awaited.pop_front();
    sb.report($sformatf("no result for query, expected value %0d segment %0d",
                        e.value, e.segment));
  endtask

endmodule
